FILE: rtl/core/uprc_pkg.sv
// ---------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and digit helpers for the decoder.
// ---------------------------------------------------------------------------
package uprc_pkg;

  // Characters with a special meaning in an encoded URL.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Escape tracking state of the front end.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_t;

  // Work the back end performs for one queued command.
  typedef enum logic [1:0] {
    OP_PLAIN     = 2'd0,  // one beat: plain byte
    OP_ESC       = 2'd1,  // one beat: decoded escape
    OP_PCT_PLAIN = 2'd2   // two beats: '%' then plain byte marked last
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] held;  // first byte after '%'
    logic [7:0] data;  // current byte
    logic       last;
  } cmd_t;

  // Digit value of an escape byte; any non-alphanumeric byte yields all ones.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41 + 8'd10;
    end
    return v;
  endfunction

  // Byte outside an escape, with optional plus-to-space conversion.
  function automatic logic [7:0] plain_byte(input logic [7:0] c, input logic p2s);
    return (c == CH_PLUS && p2s) ? CH_SPACE : c;
  endfunction

endpackage

FILE: rtl/core/uprc_front.sv
// ---------------------------------------------------------------------------
// URL percent decoder front end
// Accepts raw bytes, tracks escape sequences and queues decode commands.
// ---------------------------------------------------------------------------
module uprc_front import uprc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd,
  output pend_t      pend
);

  pend_t      pend_next;
  logic [7:0] held;
  logic       gen;
  logic       fire;

  // A byte is taken whenever the queue has room for a command.
  assign in_ready = push_ready;
  assign fire     = in_valid && in_ready;

  // Next escape state.
  always_comb begin
    pend_next = pend;
    if (fire) begin
      case (pend)
        PEND_PCT: begin
          pend_next = in_last ? PEND_NONE : PEND_DIGIT;
        end
        PEND_DIGIT: begin
          pend_next = PEND_NONE;
        end
        default: begin
          pend_next = (in_byte == CH_PERCENT && !in_last) ? PEND_PCT : PEND_NONE;
        end
      endcase
    end
  end

  // Command produced by the current beat.
  always_comb begin
    gen           = 1'b0;
    push_cmd.op   = OP_PLAIN;
    push_cmd.held = held;
    push_cmd.data = in_byte;
    push_cmd.last = in_last;
    case (pend)
      PEND_PCT: begin
        gen         = in_last;
        push_cmd.op = OP_PCT_PLAIN;
      end
      PEND_DIGIT: begin
        gen         = 1'b1;
        push_cmd.op = OP_ESC;
      end
      default: begin
        gen         = !(in_byte == CH_PERCENT && !in_last);
        push_cmd.op = OP_PLAIN;
      end
    endcase
  end

  assign push_valid = in_valid && gen;

  // State and held escape byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'h00;
    end else if (fire && pend == PEND_PCT && !in_last) begin
      held <= in_byte;
    end
  end

endmodule

FILE: rtl/core/uprc_queue.sv
// ---------------------------------------------------------------------------
// URL percent decoder command queue
// Short register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module uprc_queue import uprc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic head_valid,
  input  logic pop,
  output cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/uprc_back.sv
// ---------------------------------------------------------------------------
// URL percent decoder back end
// Executes queued commands and drives decoded bytes on the output channel.
// ---------------------------------------------------------------------------
module uprc_back import uprc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       plus_to_space,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       phase
);

  logic       two_beat;
  logic       beat;
  logic [7:0] dv_held;
  logic [7:0] dv_data;

  assign two_beat  = (head_cmd.op == OP_PCT_PLAIN);
  assign out_valid = head_valid;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && (!two_beat || phase);
  assign dv_held   = digit_value(head_cmd.held);
  assign dv_data   = digit_value(head_cmd.data);

  // Result byte for the current command and beat.
  always_comb begin
    case (head_cmd.op)
      OP_ESC: begin
        out_byte = {dv_held[3:0], 4'b0000} + dv_data;
        out_last = head_cmd.last;
      end
      OP_PCT_PLAIN: begin
        out_byte = phase ? plain_byte(head_cmd.data, plus_to_space) : CH_PERCENT;
        out_last = phase;
      end
      default: begin
        out_byte = plain_byte(head_cmd.data, plus_to_space);
        out_last = head_cmd.last;
      end
    endcase
  end

  // Beat counter for two-beat commands.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (pop) begin
      phase <= 1'b0;
    end else if (beat && two_beat) begin
      phase <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/url_percent_decoder.sv
// A byte that completes a result is registered in the command queue before it is output.
// Throughput: one input byte per cycle while the queue has room; a '%' one byte before the end
// yields two output beats. The queue has DEPTH entries, which sets how far input runs ahead.
// Reset (rst, synchronous) clears escape state, the queue and plus_to_space to zero.
// ---------------------------------------------------------------------------
// URL percent decoder
// Streaming percent decoder with an optional plus-to-space conversion.
// ---------------------------------------------------------------------------
module url_percent_decoder import uprc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic  plus_to_space;
  logic  push_valid;
  logic  push_ready;
  cmd_t  push_cmd;
  logic  head_valid;
  cmd_t  head_cmd;
  logic  pop;
  pend_t pend;
  logic  phase;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_to_space <= 1'b0;
    end else if (cfg_write) begin
      plus_to_space <= cfg_data;
    end
  end

  uprc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pend       (pend)
  );

  uprc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .head_cmd   (head_cmd)
  );

  uprc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .plus_to_space (plus_to_space),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .phase         (phase)
  );

  // The first beat of a two-beat command is followed by its final beat.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !phase && head_cmd.op == OP_PCT_PLAIN)
    |=> (out_valid && out_last && phase))
    else $error("two-beat command lost its second beat");

  // A '%' that is not last opens an escape instead of producing output.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && pend == PEND_NONE && in_byte == CH_PERCENT && !in_last)
    |=> (pend == PEND_PCT))
    else $error("percent did not open an escape");

  // Output valid only drops after a completed beat.
  assert property (@(posedge clk) disable iff (rst)
    ($fell(out_valid) && !$past(rst)) |-> $past(out_valid && out_ready))
    else $error("output beat withdrawn without handshake");

endmodule
